/* src/sfd_pkg.sv */
package sfd_pkg;

  localparam int unsigned SAMPLE_BITS        = 16;
  localparam int unsigned FRAC_BITS          = 8;
  localparam int unsigned STATE_BITS         = SAMPLE_BITS + FRAC_BITS;
  localparam int unsigned GAIN_BITS          = 16;
  localparam int unsigned COEF_BITS          = 17;
  localparam int unsigned DELAY_BITS         = 17;
  localparam int unsigned CFG_DATA_BITS      = 17;
  localparam int unsigned CFG_INDEX_BITS     = 3;
  localparam int unsigned OP_BITS            = STATE_BITS + 2;
  localparam int unsigned PROD_BITS          = OP_BITS + COEF_BITS + 1;
  localparam int unsigned Q16_SHIFT          = 16;
  localparam int unsigned ONE_Q16            = 65536;
  localparam int unsigned RING_DEPTH_DEFAULT = 131072;

  localparam int unsigned DELAY_RESET    = 24000;
  localparam int unsigned FB_GAIN_RESET  = 26214;
  localparam int unsigned LP_COEFF_RESET = 42538;
  localparam int unsigned HP_COEFF_RESET = 65023;
  localparam int unsigned MIX_RESET      = 32768;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [STATE_BITS-1:0]  filt_t;
  typedef logic signed [OP_BITS-1:0]     operand_t;
  typedef logic signed [PROD_BITS-1:0]   prod_t;
  typedef logic        [COEF_BITS-1:0]   coef_t;

  typedef struct packed {
    sample_t left_in;
    sample_t right_in;
  } sfd_in_t;

  typedef struct packed {
    sample_t left_out;
    sample_t right_out;
  } sfd_out_t;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_DELAY_LENGTH   = 3'd0,
    REG_FEEDBACK_GAIN  = 3'd1,
    REG_LOWPASS_COEFF  = 3'd2,
    REG_HIGHPASS_COEFF = 3'd3,
    REG_INVERT_WET     = 3'd4,
    REG_MIX_LEVEL      = 3'd5
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ADDR,
    ST_LP_MUL,
    ST_LP_UPD,
    ST_HP_MUL,
    ST_HP_UPD,
    ST_FB_MUL,
    ST_FB_UPD,
    ST_MIX_DRY,
    ST_MIX_WET,
    ST_MIX_UPD,
    ST_DONE
  } seq_state_t;

  // Round to nearest, ties toward +inf, then arithmetic shift.
  function automatic prod_t round_shift(prod_t x, int unsigned s);
    prod_t half;
    half = prod_t'(1) <<< (s - 1);
    return (x + half) >>> s;
  endfunction

  function automatic filt_t sat_state(prod_t x);
    prod_t hi;
    prod_t lo;
    hi = (prod_t'(1) <<< (STATE_BITS - 1)) - prod_t'(1);
    lo = -hi - prod_t'(1);
    if (x > hi) begin
      return hi[STATE_BITS-1:0];
    end else if (x < lo) begin
      return lo[STATE_BITS-1:0];
    end
    return x[STATE_BITS-1:0];
  endfunction

  function automatic sample_t sat_sample(prod_t x);
    prod_t hi;
    prod_t lo;
    hi = (prod_t'(1) <<< (SAMPLE_BITS - 1)) - prod_t'(1);
    lo = -hi - prod_t'(1);
    if (x > hi) begin
      return hi[SAMPLE_BITS-1:0];
    end else if (x < lo) begin
      return lo[SAMPLE_BITS-1:0];
    end
    return x[SAMPLE_BITS-1:0];
  endfunction

endpackage

/* src/stereo_filtered_feedback_delay.sv */
// Each stereo word takes ten passes through the one shared multiplier (five per
// channel) plus ring read and output load; a new input word is accepted only
// once the previous one has been loaded for output.
// A delay_length write holds in_ready low while the delay is reduced.
// Reset (rst, synchronous, active high) clears control and filter state, presets config;
// ring entries not yet written since reset read as zero, with no clearing pass.
module stereo_filtered_feedback_delay
  import sfd_pkg::*;
#(
  parameter int unsigned RING_DEPTH = RING_DEPTH_DEFAULT
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  sfd_in_t                   in_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output sfd_out_t                  out_data,
  input  logic                      cfg_we,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

  localparam int unsigned ADDR_BITS = $clog2(RING_DEPTH);

  // Sequencer
  seq_state_t state;
  seq_state_t state_next;
  logic       ch;          // 0 = left, 1 = right

  // Configuration registers
  logic [GAIN_BITS-1:0] feedback_gain;
  logic [GAIN_BITS-1:0] lowpass_coeff;
  logic [GAIN_BITS-1:0] highpass_coeff;
  logic                 invert_wet;
  coef_t                mix_level;

  // Ring addressing and fill tracking
  logic [ADDR_BITS-1:0] wp;
  logic                 wrapped;
  logic [ADDR_BITS-1:0] rd_addr;
  logic                 rd_valid;
  logic [ADDR_BITS-1:0] dl_mod;
  logic                 rem_busy;
  logic [ADDR_BITS:0]   rd_sum;
  logic [ADDR_BITS:0]   rd_sub;
  logic [ADDR_BITS-1:0] rd_calc;

  // Per-channel filter state
  filt_t lp      [2];
  filt_t hp_prev [2];
  filt_t hp_out  [2];

  // Working registers
  sample_t x_left;
  sample_t x_right;
  sample_t y_left;
  sample_t y_right;
  prod_t   acc;

  // Shared multiplier
  logic     mul_en;
  operand_t op_a;
  coef_t    op_b;
  prod_t    prod;

  // Ring ports
  sample_t left_q;
  sample_t right_q;
  logic    ring_re;
  logic    left_we;
  logic    right_we;

  // Channel-selected views and step results
  sample_t  d_raw;
  sample_t  d_eff;
  sample_t  x_cur;
  filt_t    lp_cur;
  filt_t    hp_prev_cur;
  filt_t    hp_out_cur;
  operand_t wet;
  coef_t    mix_eff;
  filt_t    lp_new;
  filt_t    hp_new;
  prod_t    fb_val;
  sample_t  ring_wdata;
  sample_t  y_new;
  logic     out_load;

  sfd_remainder #(
    .DEPTH(RING_DEPTH)
  ) u_remainder (
    .clk     (clk),
    .rst     (rst),
    .start   (cfg_we && (cfg_index == REG_DELAY_LENGTH)),
    .dividend(cfg_data[DELAY_BITS-1:0]),
    .busy    (rem_busy),
    .rem     (dl_mod)
  );

  sfd_mul u_mul (
    .clk(clk),
    .en (mul_en),
    .a  (op_a),
    .b  (op_b),
    .p  (prod)
  );

  sfd_ring_ram #(
    .DEPTH(RING_DEPTH)
  ) u_left_ring (
    .clk  (clk),
    .we   (left_we),
    .waddr(wp),
    .wdata(ring_wdata),
    .re   (ring_re),
    .raddr(rd_addr),
    .rdata(left_q)
  );

  sfd_ring_ram #(
    .DEPTH(RING_DEPTH)
  ) u_right_ring (
    .clk  (clk),
    .we   (right_we),
    .waddr(wp),
    .wdata(ring_wdata),
    .re   (ring_re),
    .raddr(rd_addr),
    .rdata(right_q)
  );

  // Accept only when idle and the delay reduction has settled.
  assign in_ready = (state == ST_IDLE) && !rem_busy;

  // Read position: wp - delay, wrapped into the ring.
  always_comb begin
    rd_sum = {1'b0, wp} + (ADDR_BITS + 1)'(RING_DEPTH) - {1'b0, dl_mod};
    rd_sub = rd_sum - (ADDR_BITS + 1)'(RING_DEPTH);
    if (rd_sum >= (ADDR_BITS + 1)'(RING_DEPTH)) begin
      rd_calc = rd_sub[ADDR_BITS-1:0];
    end else begin
      rd_calc = rd_sum[ADDR_BITS-1:0];
    end
  end

  // Channel views. An entry not yet written since reset reads as zero.
  always_comb begin
    d_raw       = ch ? right_q : left_q;
    d_eff       = rd_valid ? d_raw : '0;
    x_cur       = ch ? x_right : x_left;
    lp_cur      = lp[ch];
    hp_prev_cur = hp_prev[ch];
    hp_out_cur  = hp_out[ch];
    wet         = invert_wet ? -operand_t'(d_eff) : operand_t'(d_eff);
    mix_eff     = (mix_level > COEF_BITS'(ONE_Q16)) ? COEF_BITS'(ONE_Q16) : mix_level;
  end

  // Results taken from the registered product.
  always_comb begin
    lp_new     = sat_state(prod_t'(lp_cur) + round_shift(prod, Q16_SHIFT));
    hp_new     = sat_state(round_shift(prod, Q16_SHIFT));
    fb_val     = round_shift(prod, Q16_SHIFT + FRAC_BITS);
    ring_wdata = sat_sample(prod_t'(x_cur) + fb_val);
    y_new      = sat_sample((acc + prod) >>> Q16_SHIFT);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and multiplier operand selection.
  always_comb begin
    state_next = state;
    mul_en     = 1'b0;
    op_a       = '0;
    op_b       = '0;
    ring_re    = 1'b0;
    left_we    = 1'b0;
    right_we   = 1'b0;
    out_load   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (in_valid && in_ready) begin
          state_next = ST_ADDR;
        end
      end
      ST_ADDR: begin
        ring_re    = 1'b1;
        state_next = ST_LP_MUL;
      end
      ST_LP_MUL: begin
        // a * (d*256 - lp)
        mul_en     = 1'b1;
        op_a       = (operand_t'(d_eff) <<< FRAC_BITS) - operand_t'(lp_cur);
        op_b       = {1'b0, lowpass_coeff};
        state_next = ST_LP_UPD;
      end
      ST_LP_UPD: begin
        state_next = ST_HP_MUL;
      end
      ST_HP_MUL: begin
        // b * (hp_out + lp - hp_prev), lp already updated
        mul_en     = 1'b1;
        op_a       = operand_t'(hp_out_cur) + operand_t'(lp_cur) - operand_t'(hp_prev_cur);
        op_b       = {1'b0, highpass_coeff};
        state_next = ST_HP_UPD;
      end
      ST_HP_UPD: begin
        state_next = ST_FB_MUL;
      end
      ST_FB_MUL: begin
        mul_en     = 1'b1;
        op_a       = operand_t'(hp_out_cur);
        op_b       = {1'b0, feedback_gain};
        state_next = ST_FB_UPD;
      end
      ST_FB_UPD: begin
        left_we    = !ch;
        right_we   = ch;
        state_next = ST_MIX_DRY;
      end
      ST_MIX_DRY: begin
        mul_en     = 1'b1;
        op_a       = operand_t'(x_cur);
        op_b       = COEF_BITS'(ONE_Q16) - mix_eff;
        state_next = ST_MIX_WET;
      end
      ST_MIX_WET: begin
        mul_en     = 1'b1;
        op_a       = wet;
        op_b       = mix_eff;
        state_next = ST_MIX_UPD;
      end
      ST_MIX_UPD: begin
        state_next = ch ? ST_DONE : ST_LP_MUL;
      end
      ST_DONE: begin
        // hold here until the output register is free
        if (!out_valid || out_ready) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Control, configuration and filter state.
  always_ff @(posedge clk) begin
    if (rst) begin
      ch             <= 1'b0;
      wp             <= '0;
      wrapped        <= 1'b0;
      out_valid      <= 1'b0;
      feedback_gain  <= GAIN_BITS'(FB_GAIN_RESET);
      lowpass_coeff  <= GAIN_BITS'(LP_COEFF_RESET);
      highpass_coeff <= GAIN_BITS'(HP_COEFF_RESET);
      invert_wet     <= 1'b0;
      mix_level      <= COEF_BITS'(MIX_RESET);
      for (int i = 0; i < 2; i++) begin
        lp[i]      <= '0;
        hp_prev[i] <= '0;
        hp_out[i]  <= '0;
      end
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_FEEDBACK_GAIN:  feedback_gain  <= cfg_data[GAIN_BITS-1:0];
          REG_LOWPASS_COEFF:  lowpass_coeff  <= cfg_data[GAIN_BITS-1:0];
          REG_HIGHPASS_COEFF: highpass_coeff <= cfg_data[GAIN_BITS-1:0];
          REG_INVERT_WET:     invert_wet     <= cfg_data[0];
          REG_MIX_LEVEL:      mix_level      <= cfg_data[COEF_BITS-1:0];
          default: begin
            // delay_length goes to the remainder unit; other indexes drop
          end
        endcase
      end

      if (state == ST_LP_UPD) begin
        lp[ch] <= lp_new;
      end
      if (state == ST_HP_UPD) begin
        hp_prev[ch] <= lp_cur;
        hp_out[ch]  <= hp_new;
      end
      if (state == ST_MIX_UPD) begin
        ch <= ~ch;
      end

      if (out_load) begin
        out_valid <= 1'b1;
        // advance the write position; once it wraps every entry is live
        if (wp == ADDR_BITS'(RING_DEPTH - 1)) begin
          wp      <= '0;
          wrapped <= 1'b1;
        end else begin
          wp <= wp + ADDR_BITS'(1);
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_valid && in_ready) begin
      x_left  <= in_data.left_in;
      x_right <= in_data.right_in;
      rd_addr <= rd_calc;
    end
    if (state == ST_ADDR) begin
      rd_valid <= wrapped || (rd_addr < wp);
    end
    if (state == ST_MIX_WET) begin
      acc <= prod + (prod_t'(1) <<< (Q16_SHIFT - 1));
    end
    if (state == ST_MIX_UPD) begin
      if (ch) begin
        y_right <= y_new;
      end else begin
        y_left <= y_new;
      end
    end
    if (out_load) begin
      out_data.left_out  <= y_left;
      out_data.right_out <= y_right;
    end
  end

`ifndef NO_ASSERTIONS
  // The write position only moves when a word is loaded for output.
  a_wp_moves_on_done: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && (wp != $past(wp))) |-> ($past(state) == ST_DONE))
    else $error("write position moved outside output load");

  // Each word starts with the left channel.
  a_left_first: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ADDR) |-> (ch == 1'b0))
    else $error("channel select not on left at ring read");

  // A new output word only appears from the load step.
  a_out_from_done: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && $rose(out_valid)) |-> ($past(state) == ST_DONE))
    else $error("out_valid rose outside output load");

  // Ring writes happen once per channel, never during reads.
  a_ring_write_step: assert property (@(posedge clk) disable iff (rst)
    (left_we || right_we) |-> ((state == ST_FB_UPD) && !ring_re && !(left_we && right_we)))
    else $error("ring write outside feedback step");
`endif

endmodule

/* src/sfd_ring_ram.sv */
module sfd_ring_ram
  import sfd_pkg::*;
#(
  parameter int unsigned DEPTH = RING_DEPTH_DEFAULT
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  sample_t                  wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output sample_t                  rdata
);

  sample_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* src/sfd_remainder.sv */
module sfd_remainder
  import sfd_pkg::*;
#(
  parameter int unsigned DEPTH = RING_DEPTH_DEFAULT
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [DELAY_BITS-1:0]    dividend,
  output logic                     busy,
  output logic [$clog2(DEPTH)-1:0] rem
);

  localparam int unsigned ADDR_BITS = $clog2(DEPTH);
  localparam int unsigned WIDE_BITS = DELAY_BITS + ADDR_BITS + 2;
  localparam int unsigned RESET_REM = DELAY_RESET % DEPTH;
  // Depth reciprocal scaled by 2^DELAY_BITS, rounded down: the quotient
  // estimate is exact or one short, so one compare and subtract finishes it.
  localparam int unsigned RECIP     = (1 << DELAY_BITS) / DEPTH;

  logic [DELAY_BITS-1:0] num;
  logic [WIDE_BITS-1:0]  quo;
  logic [WIDE_BITS-1:0]  diff;
  logic [WIDE_BITS-1:0]  scaled;
  logic [WIDE_BITS-1:0]  back;
  logic [WIDE_BITS-1:0]  diff_sub;
  logic [1:0]            steps;
  logic [ADDR_BITS-1:0]  part;
  logic [ADDR_BITS-1:0]  part_next;

  always_comb begin
    scaled   = WIDE_BITS'(num) * WIDE_BITS'(RECIP);
    back     = quo * WIDE_BITS'(DEPTH);
    diff_sub = diff - WIDE_BITS'(DEPTH);
    if (diff >= WIDE_BITS'(DEPTH)) begin
      part_next = diff_sub[ADDR_BITS-1:0];
    end else begin
      part_next = diff[ADDR_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      steps <= '0;
      part  <= ADDR_BITS'(RESET_REM);
    end else if (start) begin
      steps <= 2'd3;
    end else if (steps != '0) begin
      steps <= steps - 2'd1;
      if (steps == 2'd1) begin
        part <= part_next;
      end
    end
  end

  // Estimate the quotient, take back its multiple, then correct once.
  always_ff @(posedge clk) begin
    if (start) begin
      num <= dividend;
    end
    if (steps == 2'd3) begin
      quo <= scaled >> DELAY_BITS;
    end
    if (steps == 2'd2) begin
      diff <= WIDE_BITS'(num) - back;
    end
  end

  assign busy = (steps != '0);
  assign rem  = part;

endmodule

/* src/sfd_mul.sv */
module sfd_mul
  import sfd_pkg::*;
(
  input  logic     clk,
  input  logic     en,
  input  operand_t a,
  input  coef_t    b,
  output prod_t    p
);

  prod_t a_ext;
  prod_t b_ext;

  assign a_ext = prod_t'(a);
  assign b_ext = prod_t'({1'b0, b});

  always_ff @(posedge clk) begin
    if (en) begin
      p <= a_ext * b_ext;
    end
  end

endmodule
